### rtl/fwd_pkg.sv
package fwd_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int MASK_W       = 4;
    localparam int CH_W         = 2;
    localparam int TIME_W       = 32;
    localparam int CNT_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int TIMEOUT_REGS = 4;

    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    localparam logic              MODE_RST          = 1'b1;
    localparam logic [MASK_W-1:0] ENABLE_MASK_RST   = '0;
    localparam logic [TIME_W-1:0] TIMEOUT_TICKS_RST = TIME_W'(100);
    localparam logic [CNT_W-1:0]  MISS_LIMIT_RST    = CNT_W'(4);
    localparam logic [CNT_W-1:0]  PENDING_LIMIT_RST = CNT_W'(5);

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_FEEDBACK = 1'b1
    } op_t;

    typedef enum logic {
        MODE_GATED    = 1'b0,
        MODE_SEPARATE = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE          = 3'd0,
        REG_ENABLE_MASK   = 3'd1,
        REG_TIMEOUT_0     = 3'd2,
        REG_TIMEOUT_1     = 3'd3,
        REG_TIMEOUT_2     = 3'd4,
        REG_TIMEOUT_3     = 3'd5,
        REG_MISS_LIMIT    = 3'd6,
        REG_PENDING_LIMIT = 3'd7
    } cfg_reg_t;

    // settings shared by every channel
    typedef struct packed {
        mode_t            mode;
        logic [CNT_W-1:0] miss_limit;
        logic [CNT_W-1:0] pending_limit;
    } chan_cfg_t;

    // per-channel strobes and flags for one event
    typedef struct packed {
        logic tick;
        logic feedback;
        logic enabled;
        logic pending;
    } chan_ctl_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
        sat_inc = (cnt == CNT_MAX) ? CNT_MAX : cnt + CNT_W'(1);
    endfunction

endpackage

### rtl/fwd_if.sv
interface fwd_event_if
    import fwd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] now_time;
    logic [MASK_W-1:0] pending_mask;

    modport source (output valid, output operation, output channel, output now_time,
                    output pending_mask, input ready);
    modport sink   (input valid, input operation, input channel, input now_time,
                    input pending_mask, output ready);
endinterface

interface fwd_result_if
    import fwd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] timeout_mask;
    logic              fault_latched;

    modport source (output valid, output timeout_mask, output fault_latched, input ready);
    modport sink   (input valid, input timeout_mask, input fault_latched, output ready);
endinterface

### rtl/feedback_timeout_watchdog_top.sv
// Feedback timeout watchdog for up to CHANNELS feedback channels. Each event transfer is either a
// feedback event (stamps the channel's last receive time with now_time) or a timer tick (checks
// every channel: elapsed time since last feedback against its timeout, the late counter and, in
// separate mode, the pending-request counter against their limits). Every event yields exactly
// one result transfer carrying the per-channel timeout mask and the sticky fault flag, which only
// reset clears. Throughput is one event per clock unless the result register is held; events pass
// the input register, then the result register. All channels update side by side, each with a
// 32-bit wrapping subtract and compare plus 8-bit counter steps. Configuration registers are
// written through cfg_we/cfg_index/cfg_data and must only change while no event is in flight.
module feedback_timeout_watchdog_top
    import fwd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fwd_event_if.sink             event_ch,
    fwd_result_if.source          result_ch
);

    // configuration registers
    logic              mode_reg;
    logic [MASK_W-1:0] enable_mask_reg;
    logic [TIME_W-1:0] timeout_ticks_reg [TIMEOUT_REGS];
    logic [CNT_W-1:0]  miss_limit_reg;
    logic [CNT_W-1:0]  pending_limit_reg;

    // input stage
    logic              in_valid_reg;
    logic              in_op_reg;
    logic [CH_W-1:0]   in_ch_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic [MASK_W-1:0] in_pend_reg;

    // result stage
    logic              out_valid_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic              out_fault_reg;
    logic              sticky_reg;

    logic              advance;
    logic              accept;
    logic              is_tick;
    logic              is_feedback;
    logic [CHANNELS-1:0] to_next;
    logic [CHANNELS-1:0] fault_vec;
    logic [MASK_W-1:0] mask_next;
    logic              sticky_next;
    chan_cfg_t         chan_cfg;

    // the input stage moves on whenever the result register is free or being drained
    assign advance        = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign event_ch.ready = !in_valid_reg || advance;
    assign accept         = event_ch.valid && event_ch.ready;

    assign is_tick     = advance && (in_op_reg == OP_TICK);
    assign is_feedback = advance && (in_op_reg == OP_FEEDBACK);

    assign chan_cfg.mode          = mode_t'(mode_reg);
    assign chan_cfg.miss_limit    = miss_limit_reg;
    assign chan_cfg.pending_limit = pending_limit_reg;

    // config write port, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_RST;
            enable_mask_reg   <= ENABLE_MASK_RST;
            for (int k = 0; k < TIMEOUT_REGS; k++)
            begin
                timeout_ticks_reg[k] <= TIMEOUT_TICKS_RST;
            end
            miss_limit_reg    <= MISS_LIMIT_RST;
            pending_limit_reg <= PENDING_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:          mode_reg             <= cfg_data[0];
                REG_ENABLE_MASK:   enable_mask_reg      <= cfg_data[MASK_W-1:0];
                REG_TIMEOUT_0:     timeout_ticks_reg[0] <= cfg_data[TIME_W-1:0];
                REG_TIMEOUT_1:     timeout_ticks_reg[1] <= cfg_data[TIME_W-1:0];
                REG_TIMEOUT_2:     timeout_ticks_reg[2] <= cfg_data[TIME_W-1:0];
                REG_TIMEOUT_3:     timeout_ticks_reg[3] <= cfg_data[TIME_W-1:0];
                REG_MISS_LIMIT:    miss_limit_reg       <= cfg_data[CNT_W-1:0];
                REG_PENDING_LIMIT: pending_limit_reg    <= cfg_data[CNT_W-1:0];
                default:           mode_reg             <= mode_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (event_ch.ready)
        begin
            in_valid_reg <= event_ch.valid;
        end
    end

    // input register payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg   <= event_ch.operation;
            in_ch_reg   <= event_ch.channel;
            in_now_reg  <= event_ch.now_time;
            in_pend_reg <= event_ch.pending_mask;
        end
    end

    // one update slice per channel
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        localparam int LIM_IDX = (g < TIMEOUT_REGS) ? g : TIMEOUT_REGS - 1;
        chan_ctl_t ctl;

        assign ctl.tick = is_tick;
        // channels past the mask width have no enable or pending bit and no channel code
        if (g < MASK_W)
        begin : g_low
            assign ctl.enabled  = enable_mask_reg[g];
            assign ctl.pending  = in_pend_reg[g];
            assign ctl.feedback = is_feedback && (in_ch_reg == CH_W'(g));
        end
        else
        begin : g_high
            assign ctl.enabled  = 1'b0;
            assign ctl.pending  = 1'b0;
            assign ctl.feedback = 1'b0;
        end

        fwd_chan u_chan (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctl            (ctl),
            .cfg            (chan_cfg),
            .now_time       (in_now_reg),
            .limit          (timeout_ticks_reg[LIM_IDX]),
            .timed_out_next (to_next[g]),
            .fault          (fault_vec[g])
        );
    end

    // only the low channels show up in the mask
    for (genvar m = 0; m < MASK_W; m++)
    begin : g_mask
        if (m < CHANNELS)
        begin : g_on
            assign mask_next[m] = to_next[m];
        end
        else
        begin : g_off
            assign mask_next[m] = 1'b0;
        end
    end

    assign sticky_next = sticky_reg || (|fault_vec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                sticky_reg    <= sticky_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mask_reg  <= mask_next;
            out_fault_reg <= sticky_next;
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.timeout_mask  = out_mask_reg;
    assign result_ch.fault_latched = out_fault_reg;

    // fault flag never drops once set
    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sticky_reg |=> sticky_reg)
        else $error("sticky fault cleared");

    // a timed-out channel in a result always comes with the fault flag
    a_mask_implies_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (|out_mask_reg)) |-> out_fault_reg)
        else $error("timeout reported without fault flag");

    // a held input item keeps its payload until it moves on
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=>
        (in_valid_reg && $stable(in_op_reg) && $stable(in_ch_reg) &&
         $stable(in_now_reg) && $stable(in_pend_reg)))
        else $error("input register lost a held item");

endmodule

### rtl/fwd_chan.sv
module fwd_chan
    import fwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  chan_ctl_t         ctl,
    input  chan_cfg_t         cfg,
    input  logic [TIME_W-1:0] now_time,
    input  logic [TIME_W-1:0] limit,
    output logic              timed_out_next,
    output logic              fault
);

    logic [TIME_W-1:0] last_rx_reg, last_rx_next;
    logic [CNT_W-1:0]  miss_reg, miss_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic              timed_out_reg;
    logic [TIME_W-1:0] elapsed;
    logic              late;

    assign elapsed = now_time - last_rx_reg;
    assign late    = elapsed > limit;

    always_comb
    begin
        last_rx_next   = last_rx_reg;
        miss_next      = miss_reg;
        pend_next      = pend_reg;
        timed_out_next = timed_out_reg;
        fault          = 1'b0;
        if (ctl.feedback)
        begin
            last_rx_next = now_time;
        end
        else if (ctl.tick)
        begin
            if (cfg.mode == MODE_SEPARATE)
            begin
                // disabled channel holds everything
                if (ctl.enabled)
                begin
                    pend_next      = ctl.pending ? sat_inc(pend_reg) : '0;
                    miss_next      = late ? sat_inc(miss_reg) : '0;
                    timed_out_next = (miss_next > cfg.miss_limit) ||
                                     (pend_next > cfg.pending_limit);
                    fault          = timed_out_next;
                end
            end
            else
            begin
                miss_next      = (ctl.pending && ctl.enabled && late) ? sat_inc(miss_reg) : '0;
                timed_out_next = miss_next > cfg.miss_limit;
                fault          = timed_out_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rx_reg   <= '0;
            miss_reg      <= '0;
            pend_reg      <= '0;
            timed_out_reg <= 1'b0;
        end
        else
        begin
            last_rx_reg   <= last_rx_next;
            miss_reg      <= miss_next;
            pend_reg      <= pend_next;
            timed_out_reg <= timed_out_next;
        end
    end

endmodule
